/* sv/particle_integrate_collide_defines.svh */
// ---------------------------------------------------------------------------
// Particle integrate and collide: assertion macros
// Shared concurrent assertion forms, clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_INTEGRATE_COLLIDE_DEFINES_SVH
`define PARTICLE_INTEGRATE_COLLIDE_DEFINES_SVH

// same-cycle implication
`define PIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pic assertion failed");

// next-cycle implication
`define PIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pic assertion failed");

`endif

/* sv/pic_pkg.sv */
// ---------------------------------------------------------------------------
// Particle integrate and collide: package
// States, operation codes, register indexes and Q16.16 helpers.
// ---------------------------------------------------------------------------
package pic_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_USE,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_AGE,
        OP_GRAV,
        OP_EULER,
        OP_VDT,
        OP_DOT,
        OP_NV,
        OP_VB,
        OP_VT,
        OP_SV,
        OP_PF,
        OP_PH
    } op_t;

    typedef enum logic [2:0] {
        REG_FRAME_STEP    = 3'd0,
        REG_ACCEL_X       = 3'd1,
        REG_ACCEL_Y       = 3'd2,
        REG_ACCEL_Z       = 3'd3,
        REG_BOUNCE        = 3'd4,
        REG_FRICTION      = 3'd5,
        REG_REMOVE_ON_HIT = 3'd6,
        REG_RAYCAST_LIMIT = 3'd7
    } reg_idx_t;

    typedef logic signed [51:0] wide_t;

    localparam logic [31:0]        FRAME_STEP_RST = 32'd1092;
    localparam logic signed [31:0] ACCEL_Z_RST    = -32'sd655360;
    localparam logic [1:0]         LAST_LANE      = 2'd2;

    function automatic logic signed [31:0] sat32(input wide_t x);
        if (x > 52'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -52'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic wide_t widen32(input logic signed [31:0] x);
        return {{20{x[31]}}, x};
    endfunction

endpackage

/* sv/pic_if.sv */
// ---------------------------------------------------------------------------
// Particle integrate and collide: channel interfaces
// Valid/ready channels for particle items and updated particle results.
// ---------------------------------------------------------------------------
interface pic_in_if;
    logic               valid;
    logic               ready;
    logic               first_of_tick;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [15:0]        age;
    logic [31:0]        age_rate;
    logic [16:0]        hit_factor;
    logic [47:0]        hit_normal;

    modport source (
        output valid, first_of_tick, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output age, age_rate, hit_factor, hit_normal,
        input  ready
    );
    modport sink (
        input  valid, first_of_tick, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  age, age_rate, hit_factor, hit_normal,
        output ready
    );
endinterface

interface pic_out_if;
    logic               valid;
    logic               ready;
    logic               removed;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [15:0]        new_age;
    logic               collision_checked;

    modport source (
        output valid, removed, new_pos_x, new_pos_y, new_pos_z,
        output new_vel_x, new_vel_y, new_vel_z, new_age, collision_checked,
        input  ready
    );
    modport sink (
        input  valid, removed, new_pos_x, new_pos_y, new_pos_z,
        input  new_vel_x, new_vel_y, new_vel_z, new_age, collision_checked,
        output ready
    );
endinterface

/* sv/particle_integrate_collide.sv */
// ---------------------------------------------------------------------------
// Particle integrate and collide: top level
// One Euler step with collision response on a shared 33x33 multiplier.
// ---------------------------------------------------------------------------
// Steps: an expired particle stops after the age multiply; other items run
// gravity and position updates, and a hit adds the response unless it
// removes the particle. Each multiply has a product state and a use state.
// A new item is accepted only in idle; the single multiplier serialises all.
// Reset: sequencer idle, output empty, registers to defaults, budget zero.
module particle_integrate_collide (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    pic_in_if.sink      item,
    pic_out_if.source   result
);
    import pic_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic [1:0] idx_reg;

    logic [31:0]        frame_step_reg;
    logic signed [31:0] accel_reg [3];
    logic [18:0]        bounce_reg;
    logic [16:0]        friction_reg;
    logic               remove_on_hit_reg;
    logic [15:0]        raycast_limit_reg;
    logic [15:0]        budget_reg;

    logic signed [31:0] p_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] p1_reg [3];
    logic signed [15:0] n_reg [3];
    logic [15:0]        age_reg;
    logic [31:0]        rate_reg;
    logic [16:0]        f_reg;
    logic signed [65:0] prod_reg;
    wide_t              acc_reg;
    logic signed [31:0] dot_reg;
    logic signed [31:0] nv_reg;
    logic signed [31:0] tv_reg;
    logic signed [31:0] sv_reg;
    wide_t              vb_reg;
    wide_t              pf_reg;
    logic               removed_reg;
    logic               checked_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_removed_reg;
    logic signed [31:0] out_pos_reg [3];
    logic signed [31:0] out_vel_reg [3];
    logic [15:0]        out_age_reg;
    logic               out_checked_reg;

    logic signed [32:0] opa, opb;
    wide_t              sh16, sh14, dot_sum;
    logic [48:0]        nage_sum;
    logic               expired, last, use_finish, out_free, accept;
    logic signed [31:0] vdt_sat, nv_sat;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign last     = (idx_reg == LAST_LANE);
    assign sh16     = {{2{prod_reg[65]}}, prod_reg[65:16]};
    assign sh14     = prod_reg[65:14];
    assign nage_sum = {33'd0, age_reg} + {1'b0, prod_reg[63:16]};
    assign expired  = (nage_sum[48:16] != 33'd0);
    assign dot_sum  = acc_reg + prod_reg[51:0];
    assign vdt_sat  = sat32(sh16);
    assign nv_sat   = sat32(sh14);

    // multiplier operand select
    always_comb
    begin
        opa = '0;
        opb = $signed({1'b0, frame_step_reg});
        unique case (op_reg)
            OP_AGE:
            begin
                opa = $signed({1'b0, rate_reg});
            end
            OP_GRAV:
            begin
                opa = {accel_reg[idx_reg][31], accel_reg[idx_reg]};
            end
            OP_EULER, OP_VDT, OP_SV:
            begin
                opa = {v_reg[idx_reg][31], v_reg[idx_reg]};
            end
            OP_DOT:
            begin
                opa = {v_reg[idx_reg][31], v_reg[idx_reg]};
                opb = {{17{n_reg[idx_reg][15]}}, n_reg[idx_reg]};
            end
            OP_NV:
            begin
                opa = {dot_reg[31], dot_reg};
                opb = {{17{n_reg[idx_reg][15]}}, n_reg[idx_reg]};
            end
            OP_VB:
            begin
                opa = 33'sd0 - {nv_reg[31], nv_reg};
                opb = $signed({14'd0, bounce_reg});
            end
            OP_VT:
            begin
                opa = {tv_reg[31], tv_reg};
                opb = 33'sd65536 - $signed({16'd0, friction_reg});
            end
            OP_PF:
            begin
                opa = {p1_reg[idx_reg][31], p1_reg[idx_reg]}
                    - {p_reg[idx_reg][31], p_reg[idx_reg]};
                opb = $signed({16'd0, f_reg});
            end
            OP_PH:
            begin
                opa = {sv_reg[31], sv_reg};
                opb = 33'sd65536 - $signed({16'd0, f_reg});
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    always_comb
    begin
        use_finish = 1'b0;
        unique case (op_reg)
            OP_AGE:   use_finish = expired;
            OP_EULER: use_finish = last;
            OP_VDT:   use_finish = last && ((f_reg == 17'd0) || remove_on_hit_reg);
            OP_PH:    use_finish = last;
            default:  use_finish = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (item.valid) state_next = S_MUL;
            S_MUL:  state_next = S_USE;
            S_USE:  state_next = use_finish ? S_DONE : S_MUL;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        item.ready     = (state_reg == S_IDLE);
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && out_free)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    assign result.valid             = out_valid_reg;
    assign result.removed           = out_removed_reg;
    assign result.new_pos_x         = out_pos_reg[0];
    assign result.new_pos_y         = out_pos_reg[1];
    assign result.new_pos_z         = out_pos_reg[2];
    assign result.new_vel_x         = out_vel_reg[0];
    assign result.new_vel_y         = out_vel_reg[1];
    assign result.new_vel_z         = out_vel_reg[2];
    assign result.new_age           = out_age_reg;
    assign result.collision_checked = out_checked_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_step_reg    <= FRAME_STEP_RST;
            accel_reg[0]      <= '0;
            accel_reg[1]      <= '0;
            accel_reg[2]      <= ACCEL_Z_RST;
            bounce_reg        <= '0;
            friction_reg      <= '0;
            remove_on_hit_reg <= 1'b0;
            raycast_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FRAME_STEP:    frame_step_reg    <= cfg_data;
                REG_ACCEL_X:       accel_reg[0]      <= cfg_data;
                REG_ACCEL_Y:       accel_reg[1]      <= cfg_data;
                REG_ACCEL_Z:       accel_reg[2]      <= cfg_data;
                REG_BOUNCE:        bounce_reg        <= cfg_data[18:0];
                REG_FRICTION:      friction_reg      <= cfg_data[16:0];
                REG_REMOVE_ON_HIT: remove_on_hit_reg <= cfg_data[0];
                REG_RAYCAST_LIMIT: raycast_limit_reg <= cfg_data[15:0];
                default:           frame_step_reg    <= frame_step_reg;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_AGE;
            idx_reg     <= '0;
            budget_reg  <= '0;
            removed_reg <= 1'b0;
            checked_reg <= 1'b0;
        end
        else if (accept)
        begin
            op_reg      <= OP_AGE;
            idx_reg     <= '0;
            removed_reg <= 1'b0;
            checked_reg <= 1'b0;
            if (item.first_of_tick)
                budget_reg <= raycast_limit_reg;
        end
        else if (state_reg == S_USE)
        begin
            unique case (op_reg)
                OP_AGE:
                begin
                    if (expired)
                        removed_reg <= 1'b1;
                    op_reg <= OP_GRAV;
                end
                OP_GRAV:
                begin
                    idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
                    if (last)
                        op_reg <= (budget_reg != 16'd0) ? OP_VDT : OP_EULER;
                end
                OP_EULER:
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
                OP_VDT:
                begin
                    idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
                    if (last)
                    begin
                        if (f_reg == 17'd0)
                        begin
                            checked_reg <= 1'b1;
                            budget_reg  <= budget_reg - 16'd1;
                        end
                        else if (remove_on_hit_reg)
                            removed_reg <= 1'b1;
                        else
                            op_reg <= OP_DOT;
                    end
                end
                OP_DOT:
                begin
                    idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
                    if (last)
                        op_reg <= OP_NV;
                end
                OP_NV: op_reg <= OP_VB;
                OP_VB: op_reg <= OP_VT;
                OP_VT:
                begin
                    idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
                    op_reg  <= last ? OP_SV : OP_NV;
                end
                OP_SV: op_reg <= OP_PF;
                OP_PF: op_reg <= OP_PH;
                OP_PH:
                begin
                    idx_reg <= idx_reg + 2'd1;
                    op_reg  <= OP_SV;
                    if (last)
                    begin
                        checked_reg <= 1'b1;
                        budget_reg  <= budget_reg - 16'd1;
                    end
                end
                default: op_reg <= OP_AGE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg[0]  <= item.pos_x;
            p_reg[1]  <= item.pos_y;
            p_reg[2]  <= item.pos_z;
            v_reg[0]  <= item.vel_x;
            v_reg[1]  <= item.vel_y;
            v_reg[2]  <= item.vel_z;
            n_reg[0]  <= item.hit_normal[15:0];
            n_reg[1]  <= item.hit_normal[31:16];
            n_reg[2]  <= item.hit_normal[47:32];
            age_reg   <= item.age;
            rate_reg  <= item.age_rate;
            f_reg     <= item.hit_factor;
            acc_reg   <= '0;
        end
        if (state_reg == S_MUL)
            prod_reg <= opa * opb;
        if (state_reg == S_USE)
        begin
            unique case (op_reg)
                OP_AGE:   age_reg <= nage_sum[15:0];
                OP_GRAV:  v_reg[idx_reg] <= sat32(widen32(v_reg[idx_reg]) + sh16);
                OP_EULER: p_reg[idx_reg] <= sat32(widen32(p_reg[idx_reg]) + sh16);
                OP_VDT:
                begin
                    p1_reg[idx_reg] <= sat32(widen32(p_reg[idx_reg]) + widen32(vdt_sat));
                    if (f_reg == 17'd0)
                        p_reg[idx_reg] <= sat32(widen32(p_reg[idx_reg])
                                                + widen32(vdt_sat));
                end
                OP_DOT:
                begin
                    acc_reg <= dot_sum;
                    dot_reg <= sat32(dot_sum >>> 14);
                end
                OP_NV:
                begin
                    nv_reg <= nv_sat;
                    tv_reg <= sat32(widen32(v_reg[idx_reg]) - widen32(nv_sat));
                end
                OP_VB:    vb_reg <= sh16;
                OP_VT:    v_reg[idx_reg] <= sat32(vb_reg + sh16);
                OP_SV:    sv_reg <= vdt_sat;
                OP_PF:    pf_reg <= sh16;
                OP_PH:    p_reg[idx_reg] <= sat32(widen32(p_reg[idx_reg]) + pf_reg + sh16);
                default:  vb_reg <= vb_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_removed_reg <= removed_reg;
            out_checked_reg <= checked_reg && !removed_reg;
            out_age_reg     <= removed_reg ? 16'd0 : age_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_pos_reg[i] <= removed_reg ? 32'sd0 : p_reg[i];
                out_vel_reg[i] <= removed_reg ? 32'sd0 : v_reg[i];
            end
        end
    end

endmodule

/* sv/pic_checker.sv */
// ---------------------------------------------------------------------------
// Particle integrate and collide: port checker
// Watches the channels of the top level and is bound to it.
// ---------------------------------------------------------------------------
`include "particle_integrate_collide_defines.svh"

module pic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_removed,
    input logic [31:0] res_pos_x,
    input logic [31:0] res_vel_z,
    input logic [15:0] res_age,
    input logic        res_checked
);
    `PIC_ASSERT_NOW(a_removed_clear, res_valid && res_removed,
        res_age == 16'd0 && !res_checked && res_pos_x == 32'd0 && res_vel_z == 32'd0)
    `PIC_ASSERT_NEXT(a_busy_after_transfer, item_valid && item_ready, !item_ready)
    `PIC_ASSERT_NEXT(a_result_held, res_valid && !res_ready,
        res_valid && $stable(res_pos_x) && $stable(res_removed))
endmodule

bind particle_integrate_collide pic_checker u_pic_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_removed (result.removed),
    .res_pos_x   (result.new_pos_x),
    .res_vel_z   (result.new_vel_z),
    .res_age     (result.new_age),
    .res_checked (result.collision_checked)
);
